### rtl/bbf_pkg.sv
// bbf_pkg: types and constants shared by the blob bounding-box finder
// holds the token structs that travel along the cell chain and the config register indexes
`timescale 1ns / 1ps

package bbf_pkg;

    localparam int COORD_BITS   = 10;
    localparam int COUNT_BITS   = 20;
    localparam int MARGIN_BITS  = 8;
    localparam int SIDE_BITS    = 10;
    localparam int PIXEL_BITS   = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX        = '1;
    localparam logic [COORD_BITS-1:0]  FALLBACK_SIDE    = COORD_BITS'(720);
    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET     = MARGIN_BITS'(10);
    localparam logic [COUNT_BITS-1:0]  MIN_PIXELS_RESET = COUNT_BITS'(1200);
    localparam logic [SIDE_BITS-1:0]   MAX_SIDE_RESET   = SIDE_BITS'(220);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MARGIN     = 2'd0,
        CFG_MIN_PIXELS = 2'd1,
        CFG_MAX_SIDE   = 2'd2
    } t_cfg_idx;

    // pixel request walking down the chain
    typedef struct packed {
        logic                  vld;
        logic                  claimed;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
    } t_pix_tok;

    // end-of-frame selection token, carries the best box seen so far
    typedef struct packed {
        logic                  vld;
        logic                  found;
        logic [COUNT_BITS-1:0] best_count;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_sel_tok;

endpackage

### rtl/bbf_cell.sv
// bbf_cell: one box slot of the chain, holds bounds, pixel count and a used flag
// tests and absorbs passing pixels, scores itself for the selection token and clears
// depends on bbf_pkg
`timescale 1ns / 1ps

module bbf_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [bbf_pkg::MARGIN_BITS-1:0] i_margin,
    input  logic [bbf_pkg::SIDE_BITS-1:0]   i_max_side,
    input  bbf_pkg::t_pix_tok              i_pix,
    input  bbf_pkg::t_sel_tok              i_sel,
    output bbf_pkg::t_pix_tok              o_pix,
    output bbf_pkg::t_sel_tok              o_sel
);

    localparam int EXT_W = bbf_pkg::COORD_BITS + 1;
    localparam int RAT_W = bbf_pkg::COORD_BITS + 6;

    logic                               r_used;
    logic [bbf_pkg::COORD_BITS-1:0]     r_left, r_top, r_right, r_bottom;
    logic [bbf_pkg::COUNT_BITS-1:0]     r_count;
    bbf_pkg::t_pix_tok                  r_pix, n_pix;
    bbf_pkg::t_sel_tok                  r_sel, n_sel;
    logic                               n_used;

    logic [EXT_W-1:0] x_m, y_m, right_m, bottom_m;
    logic             in_box, hit, create, qual;
    logic [bbf_pkg::COORD_BITS-1:0] w, h;
    logic [RAT_W-1:0] w_ext, h_ext, h2, w3, h50, w33;

    // membership: left-m < x < right+m, top-m < y < bottom+m
    always_comb begin
        x_m      = {1'b0, i_pix.col} + EXT_W'(i_margin);
        y_m      = {1'b0, i_pix.row} + EXT_W'(i_margin);
        right_m  = {1'b0, r_right}   + EXT_W'(i_margin);
        bottom_m = {1'b0, r_bottom}  + EXT_W'(i_margin);
        in_box   = (x_m > {1'b0, r_left}) && ({1'b0, i_pix.col} < right_m) &&
                   (y_m > {1'b0, r_top})  && ({1'b0, i_pix.row} < bottom_m);
        hit      = i_pix.vld && !i_pix.claimed && r_used && in_box;
        create   = i_pix.vld && !i_pix.claimed && !r_used;
    end

    // ratio test 0.66 < h/w < 1.5 as 2h < 3w and 50h > 33w
    always_comb begin
        w     = r_right - r_left;
        h     = r_bottom - r_top;
        w_ext = RAT_W'(w);
        h_ext = RAT_W'(h);
        h2    = h_ext * RAT_W'(2);
        w3    = w_ext * RAT_W'(3);
        h50   = h_ext * RAT_W'(50);
        w33   = w_ext * RAT_W'(33);
        qual  = r_used && (r_count > i_sel.best_count) && (h2 < w3) && (h50 > w33) &&
                (h < i_max_side) && (w < i_max_side);
    end

    always_comb begin
        n_pix         = i_pix;
        n_pix.claimed = i_pix.claimed | hit | create;

        n_sel = i_sel;
        if (i_sel.vld && qual) begin
            n_sel.found      = 1'b1;
            n_sel.best_count = r_count;
            n_sel.left       = r_left;
            n_sel.top        = r_top;
            n_sel.right      = r_right;
            n_sel.bottom     = r_bottom;
        end

        n_used = r_used;
        if (i_sel.vld) begin
            n_used = 1'b0;
        end else if (create) begin
            n_used = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_pix.vld <= 1'b0;
            r_sel.vld <= 1'b0;
        end else if (i_en) begin
            r_used <= n_used;
            r_pix  <= n_pix;
            r_sel  <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (create) begin
                r_left   <= i_pix.col;
                r_right  <= i_pix.col;
                r_top    <= i_pix.row;
                r_bottom <= i_pix.row;
                r_count  <= bbf_pkg::COUNT_BITS'(1);
            end else if (hit) begin
                if (i_pix.col > r_right) begin
                    r_right <= i_pix.col;
                end else if (i_pix.col < r_left) begin
                    r_left <= i_pix.col;
                end
                if (i_pix.row > r_bottom) begin
                    r_bottom <= i_pix.row;
                end else if (i_pix.row < r_top) begin
                    r_top <= i_pix.row;
                end
                if (r_count != bbf_pkg::COUNT_MAX) begin
                    r_count <= r_count + bbf_pkg::COUNT_BITS'(1);
                end
            end
        end
    end

    assign o_pix = r_pix;
    assign o_sel = r_sel;

endmodule

### rtl/blob_bounding_box_finder.sv
// Pixels enter a chain of MAX_BOXES box cells and move one cell per clock, so one pixel
// is accepted every cycle unless the chain holds; the box table is never scanned in place.
// An end-of-frame request sends a selection token right behind its pixel, the input takes
// no request while the token waits, and the box comes out once the token has passed every
// cell and the output register. The cells clear as the token passes, so the next frame
// follows at once. The chain holds only when a new result meets a full output register.
// blob_bounding_box_finder: top level, config registers, chain of bbf_cell, output register
// depends on bbf_pkg and bbf_cell
`timescale 1ns / 1ps

module blob_bounding_box_finder #(
    parameter int MAX_BOXES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bbf_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [bbf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [bbf_pkg::PIXEL_BITS-1:0]     i_pixel,
    input  logic [bbf_pkg::COORD_BITS-1:0]     i_col,
    input  logic [bbf_pkg::COORD_BITS-1:0]     i_row,
    input  logic                               i_end_of_frame,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [bbf_pkg::COORD_BITS-1:0]     o_box_left,
    output logic [bbf_pkg::COORD_BITS-1:0]     o_box_top,
    output logic [bbf_pkg::COORD_BITS-1:0]     o_box_right,
    output logic [bbf_pkg::COORD_BITS-1:0]     o_box_bottom,
    output logic                               o_found,
    output logic                               o_overflow
);

    logic [bbf_pkg::MARGIN_BITS-1:0] r_margin;
    logic [bbf_pkg::COUNT_BITS-1:0]  r_min_pixels;
    logic [bbf_pkg::SIDE_BITS-1:0]   r_max_side;

    logic r_eof_pend, n_eof_pend;
    logic r_dropped, n_dropped;
    logic r_out_valid, n_out_valid;
    logic r_out_found, r_out_ovf;
    logic [bbf_pkg::COORD_BITS-1:0] r_out_left, r_out_top, r_out_right, r_out_bottom;

    logic en, in_acc, sel_exit;

    bbf_pkg::t_pix_tok pix_chain [0:MAX_BOXES];
    bbf_pkg::t_sel_tok sel_chain [0:MAX_BOXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin     <= bbf_pkg::MARGIN_RESET;
            r_min_pixels <= bbf_pkg::MIN_PIXELS_RESET;
            r_max_side   <= bbf_pkg::MAX_SIDE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bbf_pkg::CFG_MARGIN: begin
                    r_margin <= i_cfg_data[bbf_pkg::MARGIN_BITS-1:0];
                end
                bbf_pkg::CFG_MIN_PIXELS: begin
                    r_min_pixels <= i_cfg_data[bbf_pkg::COUNT_BITS-1:0];
                end
                bbf_pkg::CFG_MAX_SIDE: begin
                    r_max_side <= i_cfg_data[bbf_pkg::SIDE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // chain holds only when a result must leave and the output is still occupied
    assign sel_exit   = sel_chain[MAX_BOXES].vld;
    assign en         = !(sel_exit && r_out_valid && !i_out_ready);
    assign o_in_ready = en && !r_eof_pend;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        pix_chain[0].vld     = in_acc && (i_pixel != '0);
        pix_chain[0].claimed = 1'b0;
        pix_chain[0].col     = i_col;
        pix_chain[0].row     = i_row;

        sel_chain[0].vld        = r_eof_pend;
        sel_chain[0].found      = 1'b0;
        sel_chain[0].best_count = r_min_pixels;
        sel_chain[0].left       = '0;
        sel_chain[0].top        = '0;
        sel_chain[0].right      = bbf_pkg::FALLBACK_SIDE;
        sel_chain[0].bottom     = bbf_pkg::FALLBACK_SIDE;
    end

    for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
        bbf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_margin   (r_margin),
            .i_max_side (r_max_side),
            .i_pix      (pix_chain[k]),
            .i_sel      (sel_chain[k]),
            .o_pix      (pix_chain[k+1]),
            .o_sel      (sel_chain[k+1])
        );
    end

    always_comb begin
        n_eof_pend = r_eof_pend;
        n_dropped  = r_dropped;
        if (en) begin
            n_eof_pend = in_acc && i_end_of_frame;
            if (sel_exit) begin
                n_dropped = 1'b0;
            end else if (pix_chain[MAX_BOXES].vld && !pix_chain[MAX_BOXES].claimed) begin
                n_dropped = 1'b1;
            end
        end

        n_out_valid = r_out_valid;
        if (en && sel_exit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_pend  <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_eof_pend  <= n_eof_pend;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && sel_exit) begin
            r_out_left   <= sel_chain[MAX_BOXES].left;
            r_out_top    <= sel_chain[MAX_BOXES].top;
            r_out_right  <= sel_chain[MAX_BOXES].right;
            r_out_bottom <= sel_chain[MAX_BOXES].bottom;
            r_out_found  <= sel_chain[MAX_BOXES].found;
            r_out_ovf    <= r_dropped;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_box_left   = r_out_left;
    assign o_box_top    = r_out_top;
    assign o_box_right  = r_out_right;
    assign o_box_bottom = r_out_bottom;
    assign o_found      = r_out_found;
    assign o_overflow   = r_out_ovf;

endmodule
